### rtl/bpi_pkg.sv
// Shared types, codes and field widths of the bucket pair insert block.
// Used by bpi_ctrl, bpi_dpath and bucket_pair_insert; depends on nothing.
package bpi_pkg;

	localparam int BUCKETS_DEF    = 1024;
	localparam int SLOTS_DEF      = 16;
	localparam int NONCE_BITS_DEF = 32;

	localparam int IDX_W       = 10;
	localparam int NONCE_W     = 32;
	localparam int NONCE_MAX_W = 64;
	localparam int IDX_EXT_W   = 17;
	localparam int ACT_W       = 11;
	localparam int CAP_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int SLOT_W      = 4;
	localparam int WASTE_W     = 16;
	localparam int TOTAL_W     = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;
	localparam int S_TDATA_W   = 80;
	localparam int M_TDATA_W   = 40;

	localparam logic [ACT_W-1:0]   ACT_RESET   = 11'd1024;
	localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
	localparam logic [WASTE_W-1:0] WASTE_MAX   = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 11'h7FF;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BUCKETS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 1'd1;

	localparam logic [STATUS_W-1:0] RES_STORED = 2'd0;
	localparam logic [STATUS_W-1:0] RES_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] RES_RANGE  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic clr;
		logic rd;
		logic upd;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_busy;
	} ctl_sts_t;

endpackage

### rtl/bpi_ctrl.sv
// Controller of the bucket pair insert block: clearing pass, accept, update.
// Depends on bpi_pkg; drives bpi_dpath through ctl_cmd_t, reads ctl_sts_t.
module bpi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  bpi_pkg::ctl_sts_t sts,
	output bpi_pkg::ctl_cmd_t cmd
);
	import bpi_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.rd  = 1'b1;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!sts.out_busy) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	a_rd_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == ST_UPDATE)
		else $error("read not followed by update");

	a_clear_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_CLEAR) |-> $past(sts.clr_done))
		else $error("clearing pass left early");

endmodule

### rtl/bpi_dpath.sv
// Datapath of the bucket pair insert block: config registers, bucket state
// memory, record store, update logic and output register. Depends on bpi_pkg.
module bpi_dpath #(
	parameter int BUCKETS    = bpi_pkg::BUCKETS_DEF,
	parameter int SLOTS      = bpi_pkg::SLOTS_DEF,
	parameter int NONCE_BITS = bpi_pkg::NONCE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpi_pkg::ctl_cmd_t               cmd,
	output bpi_pkg::ctl_sts_t               sts,
	input  logic                            cfg_wen,
	input  logic [bpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpi_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [bpi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bpi_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
	import bpi_pkg::*;

	localparam int BIDX_W = $clog2(BUCKETS);
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int REC_D  = BUCKETS * SLOTS;
	localparam int REC_AW = $clog2(REC_D);
	localparam int ENT_W  = 1 + WASTE_W + FILL_W;
	localparam int REC_W  = 2 * NONCE_BITS;

	logic [ACT_W-1:0] act_q;
	logic [CAP_W-1:0] cap_q;

	logic [ENT_W-1:0] bmem [BUCKETS];
	logic [REC_W-1:0] rmem [REC_D];

	logic [BIDX_W-1:0]     clr_cnt_q;
	logic [BIDX_W-1:0]     bidx_s1;
	logic                  in_rng_s1;
	logic [NONCE_BITS-1:0] n1_s1;
	logic [NONCE_BITS-1:0] n2_s1;
	logic [ENT_W-1:0]      ent_s1;
	logic [TOTAL_W-1:0]    full_total_q;
	logic                  m_valid_q;
	logic [M_TDATA_W-1:0]  m_data_q;

	logic [IDX_W-1:0]       in_idx;
	logic [IDX_EXT_W-1:0]   idx_ext;
	logic [NONCE_MAX_W-1:0] n1_ext;
	logic [NONCE_MAX_W-1:0] n2_ext;
	logic                   in_rng;

	logic [FILL_W-1:0]  fill;
	logic [WASTE_W-1:0] waste;
	logic               full;
	logic [CMP_W-1:0]   cap_cmp;
	logic [FILL_W-1:0]  cap_eff;
	logic               has_room;

	logic [FILL_W-1:0]   fill_n;
	logic [WASTE_W-1:0]  waste_n;
	logic                full_n;
	logic                became;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	logic [WASTE_W-1:0]  res_waste;
	logic [TOTAL_W-1:0]  total_n;
	logic [REC_AW-1:0]   rec_addr;
	logic                rec_we;

	logic              bm_we;
	logic [BIDX_W-1:0] bm_waddr;
	logic [ENT_W-1:0]  bm_wdata;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RESET;
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ACTIVE_BUCKETS:  act_q <= cfg_data;
				REG_BUCKET_CAPACITY: cap_q <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// request fields
	assign in_idx  = s_axis_tdata[IDX_W-1:0];
	assign idx_ext = IDX_EXT_W'(in_idx);
	assign n1_ext  = NONCE_MAX_W'(s_axis_tdata[IDX_W +: NONCE_W]);
	assign n2_ext  = NONCE_MAX_W'(s_axis_tdata[IDX_W+NONCE_W +: NONCE_W]);
	assign in_rng  = (ACT_W'(in_idx) < act_q) && (idx_ext < IDX_EXT_W'(BUCKETS));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			bidx_s1   <= idx_ext[BIDX_W-1:0];
			in_rng_s1 <= in_rng;
			n1_s1     <= n1_ext[NONCE_BITS-1:0];
			n2_s1     <= n2_ext[NONCE_BITS-1:0];
			ent_s1    <= bmem[idx_ext[BIDX_W-1:0]];
		end
	end

	// update of one bucket
	assign fill     = ent_s1[FILL_W-1:0];
	assign waste    = ent_s1[FILL_W +: WASTE_W];
	assign full     = ent_s1[ENT_W-1];
	assign cap_cmp  = (CMP_W'(cap_q) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(cap_q);
	assign cap_eff  = cap_cmp[FILL_W-1:0];
	assign has_room = fill < cap_eff;
	assign rec_addr = REC_AW'(REC_AW'(bidx_s1) * REC_AW'(SLOTS) + REC_AW'(fill));

	always_comb begin
		fill_n     = fill;
		waste_n    = waste;
		full_n     = full;
		became     = 1'b0;
		res_status = RES_RANGE;
		res_slot   = '0;
		res_waste  = '0;
		total_n    = full_total_q;
		rec_we     = 1'b0;
		if (in_rng_s1) begin
			if (has_room) begin
				fill_n     = fill + 1'b1;
				res_status = RES_STORED;
				res_slot   = SLOT_W'(fill);
				rec_we     = cmd.upd;
			end else begin
				fill_n     = cap_eff;
				full_n     = 1'b1;
				became     = !full;
				res_status = RES_FULL;
				if (waste != WASTE_MAX) begin
					waste_n = waste + 1'b1;
				end
				if (!full && full_total_q != TOTAL_MAX) begin
					total_n = full_total_q + 1'b1;
				end
			end
			res_waste = waste_n;
		end
	end

	// bucket state memory: clearing pass or write back
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = bidx_s1;
		bm_wdata = {full_n, waste_n, fill_n};
		if (cmd.clr) begin
			bm_we    = 1'b1;
			bm_waddr = clr_cnt_q;
			bm_wdata = '0;
		end else if (cmd.upd && in_rng_s1) begin
			bm_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bmem[bm_waddr] <= bm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rmem[rec_addr] <= {n2_s1, n1_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_total_q <= '0;
		end else if (cmd.upd) begin
			full_total_q <= total_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			m_data_q <= M_TDATA_W'({total_n, res_waste, became, res_slot, res_status});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign sts.out_busy  = m_valid_q && !m_axis_tready;
	assign sts.clr_done  = clr_cnt_q == BIDX_W'(BUCKETS - 1);

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (full_total_q == $past(full_total_q)) ||
			(full_total_q == $past(full_total_q) + 1'b1))
		else $error("full total moved by more than one");

	a_valid_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(cmd.upd))
		else $error("result appeared without an update");

	a_range_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd && !in_rng_s1 |=> m_data_q[STATUS_W-1:0] == RES_RANGE)
		else $error("rejected request gave wrong status");

endmodule

### rtl/bucket_pair_insert.sv
// Top level of the bucket pair insert block.
// Depends on bpi_pkg, bpi_ctrl and bpi_dpath.
//
// Each insert has an accept step and an update step: the accepting edge reads the bucket's
// fill count, full flag and waste counter from a single-port state memory,
// and the update step writes them back, stores the nonce pair and loads the
// result register; no new insert is taken before that update is done. The result
// register lets the next insert be taken while a result waits; an update
// stalls only while a previous result is still not taken. After reset a
// clearing pass zeroes the bucket state, with s_axis_tready low; configuration
// writes are taken at any time but must only be made while the block is
// idle.
module bucket_pair_insert #(
	parameter int BUCKETS    = bpi_pkg::BUCKETS_DEF,
	parameter int SLOTS      = bpi_pkg::SLOTS_DEF,
	parameter int NONCE_BITS = bpi_pkg::NONCE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpi_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// bucket_index [9:0], nonce_first [41:10], nonce_second [73:42], zero fill
	input  logic [bpi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status [1:0], slot [5:2], became_full [6], waste_count [22:7],
	// full_total [33:23], zero fill
	output logic [bpi_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
	import bpi_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	bpi_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	bpi_dpath #(
		.BUCKETS    (BUCKETS),
		.SLOTS      (SLOTS),
		.NONCE_BITS (NONCE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### sim/bucket_pair_insert_test.sv
// Self-checking testbench for bucket_pair_insert: streams insert requests,
// predicts each result from a bucket table tracker and compares field by field.
// Depends on bpi_pkg and the bucket_pair_insert RTL.
`timescale 1ns / 1ps

module bucket_pair_insert_test;

	import bpi_pkg::*;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                became;
		logic [WASTE_W-1:0]  waste;
		logic [TOTAL_W-1:0]  total;
	} insert_result_t;

	class bucket_fill_tracker;
		int fill_level[BUCKETS_DEF];
		bit full_mark[BUCKETS_DEF];
		int waste_tally[BUCKETS_DEF];
		int full_tally;
		int active_reg;
		int capacity_reg;
		insert_result_t pending_results[$];
		int results_seen;
		int errors;

		function new();
			foreach (fill_level[i]) begin
				fill_level[i] = 0;
				full_mark[i] = 1'b0;
				waste_tally[i] = 0;
			end
			full_tally = 0;
			active_reg = ACT_RESET;
			capacity_reg = CAP_RESET;
			results_seen = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
			if (which == REG_ACTIVE_BUCKETS)
				active_reg = int'(value[ACT_W-1:0]);
			else if (which == REG_BUCKET_CAPACITY)
				capacity_reg = int'(value[CAP_W-1:0]);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void note_insert(logic [IDX_W-1:0] idx);
			insert_result_t r;
			int limit;
			int cap;
			int b;
			int cnt;
			limit = (active_reg < BUCKETS_DEF) ? active_reg : BUCKETS_DEF;
			cap = (capacity_reg < SLOTS_DEF) ? capacity_reg : SLOTS_DEF;
			b = int'(idx);
			r.slot = '0;
			r.became = 1'b0;
			r.waste = '0;
			if (b >= limit) begin
				r.status = RES_RANGE;
			end else begin
				cnt = fill_level[b];
				if (cnt < cap) begin
					fill_level[b] = cnt + 1;
					r.status = RES_STORED;
					r.slot = cnt[SLOT_W-1:0];
				end else begin
					fill_level[b] = cap;
					if (!full_mark[b]) begin
						full_mark[b] = 1'b1;
						if (full_tally < int'(TOTAL_MAX))
							full_tally++;
						r.became = 1'b1;
					end
					if (waste_tally[b] < int'(WASTE_MAX))
						waste_tally[b]++;
					r.status = RES_FULL;
				end
				r.waste = waste_tally[b][WASTE_W-1:0];
			end
			r.total = full_tally[TOTAL_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d);
			insert_result_t want;
			insert_result_t got;
			got.status = d[1:0];
			got.slot = d[5:2];
			got.became = d[6];
			got.waste = d[22:7];
			got.total = d[33:23];
			results_seen++;
			if (pending_results.size() == 0) begin
				if (errors < 10)
					$display({"result %0d: none expected, got status %0d slot %0d ",
						"became %0d waste %0d total %0d"},
						results_seen, got.status, got.slot, got.became, got.waste,
						got.total);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.slot !== want.slot ||
			    got.became !== want.became || got.waste !== want.waste ||
			    got.total !== want.total) begin
				if (errors < 10)
					$display({"result %0d: expected status %0d slot %0d became %0d waste %0d ",
						"total %0d, got status %0d slot %0d became %0d waste %0d total %0d"},
						results_seen, want.status, want.slot, want.became, want.waste,
						want.total, got.status, got.slot, got.became, got.waste, got.total);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;

	bucket_fill_tracker tracker;
	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_request = 0;
	int hold_left = 0;
	int cur_limit = -1;
	int hot_buckets[6];

	bucket_pair_insert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid === 1'b1 && m_axis_tready)
			tracker.check_result(m_axis_tdata);
	end

	task automatic send_insert(input logic [IDX_W-1:0] idx, input logic [NONCE_W-1:0] first,
		input logic [NONCE_W-1:0] second);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - IDX_W - 2 * NONCE_W){1'b0}}, second, first, idx};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_insert(idx);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
		input logic [CFG_DATA_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_reg(which, value);
		@(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				snd_idle = 13;
				rcv_idle = 55;
			end
			1: begin
				snd_idle = 55;
				rcv_idle = 13;
			end
			default: begin
				snd_idle = 0;
				rcv_idle = 0;
			end
		endcase
	endtask

	function automatic logic [IDX_W-1:0] pick_index(input int limit);
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 70 && limit > 0)
			return hot_buckets[$urandom_range(5)][IDX_W-1:0];
		if (r < 85)
			return IDX_W'($urandom_range(BUCKETS_DEF - 1));
		v = limit - 1 + int'($urandom_range(2));
		if (v < 0)
			v = 0;
		if (v > BUCKETS_DEF - 1)
			v = BUCKETS_DEF - 1;
		return v[IDX_W-1:0];
	endfunction

	task automatic run_phase(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] cap,
		input int mode, input int hold);
		int limit;
		settle();
		write_reg(REG_ACTIVE_BUCKETS, act);
		write_reg(REG_BUCKET_CAPACITY, cap);
		limit = (int'(act) < BUCKETS_DEF) ? int'(act) : BUCKETS_DEF;
		if (limit != cur_limit) begin
			foreach (hot_buckets[i])
				hot_buckets[i] = (limit > 0) ? $urandom_range(limit - 1) : 0;
			cur_limit = limit;
		end
		set_idling(mode);
		if (hold > 0)
			hold_request = hold;
		repeat (230)
			send_insert(pick_index(limit), $urandom, $urandom);
	endtask

	initial begin
		tracker = new();
		set_idling(0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill a small bucket, overflow it, then lower capacity under it
		write_reg(REG_BUCKET_CAPACITY, 11'd2);
		send_insert(10'd0, 32'h0000_0000, 32'h0000_0000);
		send_insert(10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_insert(10'd0, 32'h1234_5678, 32'h9ABC_DEF0);
		send_insert(10'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_insert(10'd1023, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
		settle();
		write_reg(REG_BUCKET_CAPACITY, 11'd1);
		send_insert(10'd0, 32'h0000_0001, 32'h8000_0000);
		send_insert(10'd1023, 32'h8000_0000, 32'h0000_0001);
		settle();
		write_reg(REG_BUCKET_CAPACITY, 11'd0);
		send_insert(10'd3, 32'hDEAD_BEEF, 32'hCAFE_F00D);
		settle();
		write_reg(REG_ACTIVE_BUCKETS, 11'd0);
		send_insert(10'd0, 32'hFFFF_FFFF, 32'h0000_0000);
		send_insert(10'd1023, 32'h0000_0000, 32'hFFFF_FFFF);
		settle();
		write_reg(REG_ACTIVE_BUCKETS, 11'd2047);
		write_reg(REG_BUCKET_CAPACITY, 11'd31);
		send_insert(10'd1023, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		send_insert(10'd7, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
		settle();
		write_reg(REG_ACTIVE_BUCKETS, 11'd1);
		send_insert(10'd1, 32'h1111_1111, 32'h2222_2222);
		send_insert(10'd0, 32'h3333_3333, 32'h4444_4444);

		run_phase(11'd16, 11'd8, 0, 0);
		run_phase(11'd16, 11'd3, 0, 0);
		run_phase(11'd1024, 11'd16, 1, 0);
		run_phase(11'd1500, 11'd31, 1, 0);
		run_phase(11'd1, 11'd1, 2, 0);
		run_phase(11'd40, 11'd5, 2, 300);

		settle();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("bucket_pair_insert: match");
		else
			$display("bucket_pair_insert: mismatch");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("bucket_pair_insert: mismatch");
		$finish;
	end

endmodule
